// ===== hdl/nmea_rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_pkg: shared codes for the RMC sentence parser
// Result kinds and the ASCII characters that steer the parse.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  // Result kinds, as carried on the item_kind output.
  typedef enum logic [3:0] {
    KIND_HOUR     = 4'd0,
    KIND_MINUTE   = 4'd1,
    KIND_SECOND   = 4'd2,
    KIND_STATUS   = 4'd3,
    KIND_LAT_CHAR = 4'd4,
    KIND_NS       = 4'd5,
    KIND_LON_CHAR = 4'd6,
    KIND_EW       = 4'd7,
    KIND_SPEED    = 4'd8,
    KIND_COURSE   = 4'd9,
    KIND_DAY      = 4'd10,
    KIND_MONTH    = 4'd11,
    KIND_YEAR     = 4'd12,
    KIND_END      = 4'd13
  } kind_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;

  // Header counter limit (one at '$'); the counter reaching one more aborts.
  localparam logic [2:0] HDR_MAX       = 3'd6;
  localparam logic [2:0] HDR_TYPE_SLOT = 3'd5;

  // Field numbers of the RMC sentence.
  localparam logic [3:0] FLD_TIME   = 4'd0;
  localparam logic [3:0] FLD_STATUS = 4'd1;
  localparam logic [3:0] FLD_LAT    = 4'd2;
  localparam logic [3:0] FLD_NS     = 4'd3;
  localparam logic [3:0] FLD_LON    = 4'd4;
  localparam logic [3:0] FLD_EW     = 4'd5;
  localparam logic [3:0] FLD_SPEED  = 4'd6;
  localparam logic [3:0] FLD_COURSE = 4'd7;
  localparam logic [3:0] FLD_DATE   = 4'd8;
  localparam logic [3:0] FLD_SAT    = 4'd15;

  localparam logic [4:0] CNT_SAT = 5'd31;

endpackage

// ===== hdl/nmea_rmc_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser: NMEA 0183 RMC sentence field extractor
// Takes one received character per beat and emits one result beat for each
// time, date, status, position, speed or course value it picks out of an
// RMC sentence, plus one end beat at the checksum marker.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                            | Direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, in_rx_byte[7:0]              | sink
//  out     | out_valid, out_ready, out_item_kind[3:0],        | source
//          | out_char_position[3:0], out_item_value[7:0]      |
//
// One character is taken per clock cycle while the result side is not stalled.
// A character's result is registered twice on its way to out_valid: first in
// the input register, then in the result register.
// The parse state is updated by a single pass of logic between the input
// register and the result register, so back-to-back characters wait only
// when the result register stalls. in_ready drops only when the input
// register holds a character and the result register holds a beat that the
// sink is not taking. rst_n (synchronous, active low) returns the parse
// state to idle; there is no memory and no clearing pass.

module nmea_rmc_sentence_parser
  import nmea_rmc_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_item_kind,
  output logic [3:0] out_char_position,
  output logic [7:0] out_item_value
);

  // Position limit for the character fields: the smaller of the parameter
  // and the sixteen positions that char_position can carry.
  localparam int         LIM   = (MAX_FIELD_CHARS < 16) ? MAX_FIELD_CHARS : 16;
  localparam logic [5:0] LIM_W = 6'(LIM);

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Result register.
  logic       out_vld_r, out_vld_nxt;
  kind_t      out_kind_r, out_kind_nxt;
  logic [3:0] out_pos_r, out_pos_nxt;
  logic [7:0] out_val_r, out_val_nxt;

  // Parse state.
  logic       in_sentence_r, in_sentence_nxt;
  logic       header_done_r, header_done_nxt;
  logic [2:0] header_count_r, header_count_nxt;
  logic [7:0] type_letter_r, type_letter_nxt;
  logic       is_rmc_r, is_rmc_nxt;
  logic [3:0] field_number_r, field_number_nxt;
  logic [4:0] field_char_count_r, field_char_count_nxt;
  logic [7:0] tens_digit_r, tens_digit_nxt;

  // The result register can take a new beat when it is empty or being drained.
  logic advance;
  logic process;

  assign advance  = !out_vld_r || out_ready;
  assign process  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  logic [7:0] b;
  logic [2:0] hdr_inc;
  logic [7:0] digit_val;
  logic [7:0] two_digit;

  assign b         = in_byte_r;
  assign hdr_inc   = header_count_r + 3'd1;
  assign digit_val = b - CH_ZERO;
  // tens * 10 + digit, kept to eight bits as the byte arithmetic wraps.
  assign two_digit = {tens_digit_r[4:0], 3'b000} + {tens_digit_r[6:0], 1'b0} + digit_val;

  always_comb begin
    in_sentence_nxt      = in_sentence_r;
    header_done_nxt      = header_done_r;
    header_count_nxt     = header_count_r;
    type_letter_nxt      = type_letter_r;
    is_rmc_nxt           = is_rmc_r;
    field_number_nxt     = field_number_r;
    field_char_count_nxt = field_char_count_r;
    tens_digit_nxt       = tens_digit_r;
    out_vld_nxt          = 1'b0;
    out_kind_nxt         = KIND_END;
    out_pos_nxt          = 4'd0;
    out_val_nxt          = 8'd0;

    if (!in_sentence_r) begin
      // Hunting for the start of a sentence.
      if (b == CH_DOLLAR) begin
        in_sentence_nxt      = 1'b1;
        header_count_nxt     = 3'd1;
        header_done_nxt      = 1'b0;
        is_rmc_nxt           = 1'b0;
        field_number_nxt     = 4'd0;
        field_char_count_nxt = 5'd0;
      end
    end else if (header_done_r) begin
      if (!is_rmc_r) begin
        // Some other sentence type: drop it at its first body character.
        is_rmc_nxt       = 1'b0;
        header_done_nxt  = 1'b0;
        header_count_nxt = 3'd1;
        in_sentence_nxt  = 1'b0;
      end else if (b == CH_STAR) begin
        in_sentence_nxt = 1'b0;
        out_vld_nxt     = 1'b1;
        out_kind_nxt    = KIND_END;
      end else if (b == CH_COMMA) begin
        if (field_number_r != FLD_SAT) begin
          field_number_nxt = field_number_r + 4'd1;
        end
        field_char_count_nxt = 5'd0;
      end else begin
        case (field_number_r)
          FLD_TIME, FLD_DATE: begin
            if (field_char_count_r < 5'd6) begin
              if (!field_char_count_r[0]) begin
                tens_digit_nxt = digit_val;
              end else begin
                out_vld_nxt  = 1'b1;
                out_val_nxt  = two_digit;
                out_kind_nxt = (field_number_r == FLD_TIME)
                             ? kind_t'({2'b00, field_char_count_r[2:1]})
                             : kind_t'(4'(KIND_DAY) + {2'b00, field_char_count_r[2:1]});
              end
            end
          end
          FLD_STATUS: begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = KIND_STATUS;
            out_val_nxt  = b;
          end
          FLD_NS: begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = KIND_NS;
            out_val_nxt  = b;
          end
          FLD_EW: begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = KIND_EW;
            out_val_nxt  = b;
          end
          FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: begin
            if ({1'b0, field_char_count_r} < LIM_W) begin
              out_vld_nxt = 1'b1;
              out_pos_nxt = field_char_count_r[3:0];
              out_val_nxt = b;
              case (field_number_r)
                FLD_LAT:   out_kind_nxt = KIND_LAT_CHAR;
                FLD_LON:   out_kind_nxt = KIND_LON_CHAR;
                FLD_SPEED: out_kind_nxt = KIND_SPEED;
                default:   out_kind_nxt = KIND_COURSE;
              endcase
            end
          end
          default: begin
            // Fields past the date carry nothing of interest.
          end
        endcase
        if (field_char_count_r != CNT_SAT) begin
          field_char_count_nxt = field_char_count_r + 5'd1;
        end
      end
    end else begin
      // Collecting the header after '$'.
      if (b == CH_COMMA) begin
        is_rmc_nxt           = (type_letter_r == CH_C);
        header_done_nxt      = 1'b1;
        header_count_nxt     = 3'd1;
        field_number_nxt     = 4'd0;
        field_char_count_nxt = 5'd0;
      end else if (b == CH_STAR) begin
        in_sentence_nxt = 1'b0;
      end else begin
        if (header_count_r == HDR_TYPE_SLOT) begin
          type_letter_nxt = b;
        end
        header_count_nxt = hdr_inc;
        if (hdr_inc > HDR_MAX) begin
          in_sentence_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r           <= 1'b0;
      out_vld_r          <= 1'b0;
      in_sentence_r      <= 1'b0;
      header_done_r      <= 1'b0;
      header_count_r     <= 3'd0;
      type_letter_r      <= CH_X;
      is_rmc_r           <= 1'b0;
      field_number_r     <= 4'd0;
      field_char_count_r <= 5'd0;
      tens_digit_r       <= 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (process) begin
        in_vld_r <= 1'b0;
      end
      if (process) begin
        out_vld_r          <= out_vld_nxt;
        in_sentence_r      <= in_sentence_nxt;
        header_done_r      <= header_done_nxt;
        header_count_r     <= header_count_nxt;
        type_letter_r      <= type_letter_nxt;
        is_rmc_r           <= is_rmc_nxt;
        field_number_r     <= field_number_nxt;
        field_char_count_r <= field_char_count_nxt;
        tens_digit_r       <= tens_digit_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (process) begin
      out_kind_r <= out_kind_nxt;
      out_pos_r  <= out_pos_nxt;
      out_val_r  <= out_val_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_item_kind     = out_kind_r;
  assign out_char_position = out_pos_r;
  assign out_item_value    = out_val_r;

  // A character position is reported only for the multi-character fields.
  a_pos_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pos_r != 4'd0) |->
      (out_kind_r == KIND_LAT_CHAR || out_kind_r == KIND_LON_CHAR ||
       out_kind_r == KIND_SPEED || out_kind_r == KIND_COURSE))
    else $error("char_position set on a kind without positions");

  // The end beat always carries a zero value.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == KIND_END) |-> (out_val_r == 8'd0))
    else $error("end beat with nonzero value");

  // An end beat closes the sentence.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (process && out_vld_nxt && out_kind_nxt == KIND_END) |=> !in_sentence_r)
    else $error("sentence still open after end beat");

  // A held character is never overwritten while the result side stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("input register lost a character under stall");

  // Results appear only inside an accepted RMC sentence body.
  a_rmc_only: assert property (@(posedge clk) disable iff (!rst_n)
    (process && out_vld_nxt) |-> (in_sentence_r && header_done_r && is_rmc_r))
    else $error("result outside an RMC sentence body");

endmodule

// ===== tb/tb_nmea_rmc_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// tb_nmea_rmc_sentence_parser: self-checking bench for the RMC field extractor
// Streams NMEA-like character traffic into the parser, mirrors its parse in a
// behavioral tracker and compares every result beat with the tracked values.
// ----------------------------------------------------------------------------

module tb_nmea_rmc_sentence_parser;
  import nmea_rmc_pkg::*;

  // The bench tracks the parser at its default field length limit.
  localparam int MAX_FIELD_CHARS = 16;
  localparam int FIELD_LIM = (MAX_FIELD_CHARS < 16) ? MAX_FIELD_CHARS : 16;
  localparam int RANDOM_BYTES = 1750;
  localparam int MAX_GAP = 14;
  // Spare cycles after the last expected result catch any beat the block
  // might emit late.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 500000;

  // One expected result beat.
  typedef struct {
    kind_t      kind;
    logic [3:0] pos;
    logic [7:0] value;
  } field_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_item_kind;
  logic [3:0] out_char_position;
  logic [7:0] out_item_value;

  nmea_rmc_sentence_parser #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_char_position(out_char_position),
    .out_item_value   (out_item_value)
  );

  // Characters still to be sent, and the result beats the parse should give.
  logic [7:0]  rx_stream[$];
  field_item_t field_results[$];

  int total_bytes = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int ends_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Gap countdowns and the quiet flags that give stretches with no idling.
  int in_gap = 0;
  int out_gap = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  // Tracked parse state, mirroring the block's registers.
  logic       st_active = 1'b0;
  logic       st_hdr_done = 1'b0;
  logic [2:0] st_hdr_cnt = 3'd0;
  logic [7:0] st_type = CH_X;
  logic       st_rmc = 1'b0;
  logic [3:0] st_field = 4'd0;
  logic [4:0] st_fcnt = 5'd0;
  logic [7:0] st_tens = 8'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the tracked parse by one accepted character and queues the
  // result beat that the character causes, if any.
  function automatic void track_byte(input logic [7:0] b);
    field_item_t r;
    logic        hit;
    hit = 1'b0;
    r.kind = KIND_END;
    r.pos = 4'd0;
    r.value = 8'd0;
    if (!st_active) begin
      // While idle only '$' matters; it opens a new header.
      if (b == CH_DOLLAR) begin
        st_active = 1'b1;
        st_hdr_cnt = 3'd1;
        st_hdr_done = 1'b0;
        st_rmc = 1'b0;
        st_field = FLD_TIME;
        st_fcnt = 5'd0;
      end
    end else if (st_hdr_done) begin
      if (!st_rmc) begin
        // A sentence of another type is dropped at its first body byte.
        st_hdr_done = 1'b0;
        st_hdr_cnt = 3'd1;
        st_active = 1'b0;
      end else if (b == CH_STAR) begin
        st_active = 1'b0;
        hit = 1'b1;
      end else if (b == CH_COMMA) begin
        if (st_field != FLD_SAT) st_field = st_field + 4'd1;
        st_fcnt = 5'd0;
      end else begin
        case (st_field)
          FLD_TIME, FLD_DATE: begin
            // Digit pairs: even indices load the tens, odd ones complete a value.
            if (st_fcnt < 5'd6) begin
              if (!st_fcnt[0]) begin
                st_tens = b - CH_ZERO;
              end else begin
                hit = 1'b1;
                r.kind = kind_t'({1'b0, st_fcnt[3:1]} +
                                 ((st_field == FLD_DATE) ? KIND_DAY : KIND_HOUR));
                r.value = st_tens * 8'd10 + b - CH_ZERO;
              end
            end
          end
          FLD_STATUS: begin
            hit = 1'b1;
            r.kind = KIND_STATUS;
            r.value = b;
          end
          FLD_NS: begin
            hit = 1'b1;
            r.kind = KIND_NS;
            r.value = b;
          end
          FLD_EW: begin
            hit = 1'b1;
            r.kind = KIND_EW;
            r.value = b;
          end
          FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: begin
            if (int'(st_fcnt) < FIELD_LIM) begin
              hit = 1'b1;
              r.pos = st_fcnt[3:0];
              r.value = b;
              case (st_field)
                FLD_LAT:   r.kind = KIND_LAT_CHAR;
                FLD_LON:   r.kind = KIND_LON_CHAR;
                FLD_SPEED: r.kind = KIND_SPEED;
                default:   r.kind = KIND_COURSE;
              endcase
            end
          end
          default: begin
          end
        endcase
        if (st_fcnt != CNT_SAT) st_fcnt = st_fcnt + 5'd1;
      end
    end else if (b == CH_COMMA) begin
      // End of header: the remembered type letter decides RMC or not.
      st_rmc = (st_type == CH_C);
      st_hdr_done = 1'b1;
      st_hdr_cnt = 3'd1;
      st_field = FLD_TIME;
      st_fcnt = 5'd0;
    end else if (b == CH_STAR) begin
      st_active = 1'b0;
    end else begin
      if (st_hdr_cnt == HDR_TYPE_SLOT) st_type = b;
      st_hdr_cnt = st_hdr_cnt + 3'd1;
      if (st_hdr_cnt > HDR_MAX) st_active = 1'b0;
    end
    if (hit) field_results.push_back(r);
  endfunction

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Input driver: holds a beat until it is taken, then waits its drawn gap
  // before presenting the next character from the stream.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_byte(in_rx_byte);
        bytes_taken++;
      end
      if (in_valid && !in_ready) begin
        // The beat is stalled; valid and payload stay as they are.
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (rx_stream.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
        if ($urandom_range(0, 47) == 0) in_quiet = !in_quiet;
        in_gap <= draw_gap(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each taken beat against the oldest expectation and
  // then stalls the result channel for a drawn number of cycles.
  always @(posedge clk) begin : result_monitor
    field_item_t want;
    int          g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (out_item_kind == KIND_END) ends_seen++;
      if (field_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d pos %0d value 0x%02h",
                   out_item_kind, out_char_position, out_item_value);
      end else begin
        want = field_results.pop_front();
        if (out_item_kind !== want.kind || out_char_position !== want.pos ||
            out_item_value !== want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected kind %0d pos %0d value 0x%02h, got %0d %0d 0x%02h",
                     results_seen, want.kind, want.pos, want.value,
                     out_item_kind, out_char_position, out_item_value);
        end
      end
      if ($urandom_range(0, 47) == 0) out_quiet = !out_quiet;
      g = draw_gap(out_quiet);
      out_gap <= g;
      out_ready <= (g == 0);
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready <= (out_gap == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_nmea_rmc_sentence_parser NOT OK");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    rx_stream.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
  endtask

  // Content styles: 0 digits and '.', 1 capital letters, 2 any byte but the
  // field and checksum delimiters, 3 any byte at all.
  function automatic logic [7:0] pick_char(input int style);
    logic [7:0] c;
    case (style)
      0: c = ($urandom_range(0, 9) == 0) ? 8'h2E : 8'(CH_ZERO + $urandom_range(0, 9));
      1: c = 8'(8'h41 + $urandom_range(0, 25));
      2: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_COMMA || c == CH_STAR) c = CH_ZERO;
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // One field of an RMC-shaped sentence. Date mostly carries six digits, time
  // six or nine, the one-letter fields one letter, and the position fields now
  // and then run past the length limit and the counter's saturation.
  task automatic add_field(input int fidx);
    int len;
    int style;
    style = ($urandom_range(0, 7) == 0) ? 2 : 0;
    if ($urandom_range(0, 15) == 0) style = 3;
    case (fidx)
      0, 8: begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 9);
        else len = (fidx == 0 && $urandom_range(0, 1) == 1) ? 9 : 6;
      end
      1, 3, 5: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
        if (style == 0) style = 1;
      end
      default: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 11);
      end
    endcase
    repeat (len) put(pick_char(style));
  endtask

  // A sentence: mostly RMC headers, sometimes another type or a random header
  // that may be empty, too long or cut short by '*'. Most end with a checksum
  // and line end; a few are left open.
  task automatic add_sentence();
    int nf;
    int hl;
    put(CH_DOLLAR);
    case ($urandom_range(0, 9))
      0: begin
        hl = $urandom_range(0, 7);
        repeat (hl) put(($urandom_range(0, 5) == 0) ? pick_char(3) : pick_char(1));
      end
      1: put_text("GPGGA");
      2: put_text("GNRMC");
      default: put_text("GPRMC");
    endcase
    put(CH_COMMA);
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : 12;
    for (int f = 0; f < nf; f++) begin
      if (f != 0) put(CH_COMMA);
      add_field(f);
    end
    if ($urandom_range(0, 9) != 0) begin
      put(CH_STAR);
      put(pick_char(0));
      put(pick_char(0));
      put(8'h0D);
      put(8'h0A);
    end
  endtask

  initial begin
    // Directed opening. An empty header with the reset type letter is not
    // RMC, so the '*' after it is dropped with the sentence.
    put_text("$,*");
    // Overlong header: the fifth character becomes the type letter and the
    // sixth aborts; the trailing 'x' is ignored while idle.
    put_text("$ABCDEFx");
    // Header aborted by '*'.
    put_text("$G*");
    // RMC with the extreme byte values in the time field, then the end beat.
    put_text("$GPRMC,");
    put(8'hFF);
    put(8'h00);
    put(CH_STAR);
    // Empty header: the type letter 'C' remembered from before makes it RMC.
    put_text("$,,V*");

    while (rx_stream.size() < 30 + RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 10)) put(pick_char(3));
      else add_sentence();
    end
    total_bytes = rx_stream.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (field_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters sent, %0d result beats checked, %0d sentence ends seen",
             bytes_taken, results_seen, ends_seen);
    if (mismatches == 0 && field_results.size() == 0) begin
      $display("tb_nmea_rmc_sentence_parser OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, field_results.size());
      $display("tb_nmea_rmc_sentence_parser NOT OK");
    end
    $finish;
  end

endmodule
